/* src/keypad_code_lock_defines.svh */
// ----------------------------------------------------------------------------
// keypad_code_lock_defines.svh
// Assertion macros used by the keypad code lock checker.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_DEFINES_SVH
`define KEYPAD_CODE_LOCK_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KCL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keypad code lock check failed");

// next-cycle implication, disabled during reset
`define KCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keypad code lock check failed");

`endif

/* src/kcl_pkg.sv */
// ----------------------------------------------------------------------------
// kcl_pkg
// Types and constants of the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

   localparam int KEY_W      = 8;
   localparam int CSR_DATA_W = 40;
   localparam int MAX_ATT_W  = 3;
   localparam int FAIL_W     = 3;

   localparam logic [KEY_W-1:0] KEY_ENTER  = 8'd10;
   localparam logic [KEY_W-1:0] KEY_DELETE = 8'd127;

   localparam logic [CSR_DATA_W-1:0] CODE_WORD_RESET    = 40'h7464323232;
   localparam logic [MAX_ATT_W-1:0]  MAX_ATTEMPTS_RESET = 3'd3;

   // request queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic {
      CSR_CODE_WORD    = 1'b0,
      CSR_MAX_ATTEMPTS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_PRINT  = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_ENTER  = 2'd2
   } key_kind_type;

   typedef enum logic [1:0] {
      ECHO_NONE  = 2'd0,
      ECHO_STAR  = 2'd1,
      ECHO_ERASE = 2'd2
   } echo_type;

   typedef enum logic [1:0] {
      VERDICT_PENDING = 2'd0,
      VERDICT_GRANTED = 2'd1,
      VERDICT_DENIED  = 2'd2
   } verdict_type;

   typedef struct packed {
      key_kind_type     kind;
      logic [KEY_W-1:0] key;
   } key_item_type;

endpackage

/* src/kcl_front.sv */
// ----------------------------------------------------------------------------
// kcl_front
// Classifies each incoming key as printable, delete or enter.
// ----------------------------------------------------------------------------
module kcl_front (
   input  logic [kcl_pkg::KEY_W-1:0] key_code,
   output kcl_pkg::key_item_type     item
);

   always_comb begin
      item.key = key_code;
      unique case (key_code)
         kcl_pkg::KEY_ENTER:  item.kind = kcl_pkg::KIND_ENTER;
         kcl_pkg::KEY_DELETE: item.kind = kcl_pkg::KIND_DELETE;
         default:             item.kind = kcl_pkg::KIND_PRINT;
      endcase
   end

endmodule

/* src/kcl_queue.sv */
// ----------------------------------------------------------------------------
// kcl_queue
// Short request queue between the classifier and the lock engine.
// ----------------------------------------------------------------------------
module kcl_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  kcl_pkg::key_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output kcl_pkg::key_item_type pop_item
);

   kcl_pkg::key_item_type               mem_ff [kcl_pkg::Q_DEPTH];
   logic [kcl_pkg::Q_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [kcl_pkg::Q_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [kcl_pkg::Q_CNT_W-1:0]         count_ff, count_in;
   logic                                push, pop;

   localparam logic [kcl_pkg::Q_PTR_W-1:0] LAST_PTR = kcl_pkg::Q_PTR_W'(kcl_pkg::Q_DEPTH - 1);
   localparam logic [kcl_pkg::Q_CNT_W-1:0] FULL_CNT = kcl_pkg::Q_CNT_W'(kcl_pkg::Q_DEPTH);

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* src/kcl_back.sv */
// ----------------------------------------------------------------------------
// kcl_back
// Lock engine: entry buffer, counters, code compare and result register.
// ----------------------------------------------------------------------------
module kcl_back #(
   parameter int CODE_LENGTH = 5,
   parameter int ECHO_MAX    = 63
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic                            csr_index,
   input  logic [kcl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            item_valid,
   output logic                            item_ready,
   input  kcl_pkg::key_item_type           item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_echo_action,
   output logic                            rsp_attempt_ended,
   output logic                            rsp_attempt_matched,
   output logic [1:0]                      rsp_verdict,
   output logic [kcl_pkg::FAIL_W-1:0]      rsp_failures_so_far
);

   localparam int SC_W   = $clog2(CODE_LENGTH + 1);
   localparam int EC_W   = $clog2(ECHO_MAX + 1);
   localparam int CODE_W = 8 * CODE_LENGTH;
   localparam int CWX_W  = (CODE_W > kcl_pkg::CSR_DATA_W) ? CODE_W : kcl_pkg::CSR_DATA_W;
   localparam logic [SC_W-1:0] SC_FULL = SC_W'(CODE_LENGTH);
   localparam logic [EC_W-1:0] EC_MAX  = EC_W'(ECHO_MAX);

   logic [kcl_pkg::CSR_DATA_W-1:0] code_word_ff;
   logic [kcl_pkg::MAX_ATT_W-1:0]  max_attempts_ff;
   logic [kcl_pkg::KEY_W-1:0]      entry_ff [CODE_LENGTH];
   logic [kcl_pkg::KEY_W-1:0]      entry_in [CODE_LENGTH];
   logic [SC_W-1:0]                stored_ff, stored_in;
   logic [EC_W-1:0]                echo_cnt_ff, echo_cnt_in;
   logic [kcl_pkg::FAIL_W-1:0]     fail_ff, fail_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   kcl_pkg::echo_type              echo_ff, echo_in;
   logic                           ended_ff, ended_in;
   logic                           matched_ff, matched_in;
   kcl_pkg::verdict_type           verdict_ff, verdict_in;
   logic [kcl_pkg::FAIL_W-1:0]     report_ff, report_in;

   logic [CWX_W-1:0]               code_ext;
   logic                           code_hit;
   logic [kcl_pkg::MAX_ATT_W-1:0]  limit;
   logic [kcl_pkg::FAIL_W-1:0]     fail_inc;
   logic                           take;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign take       = item_valid && item_ready;
   assign code_ext   = CWX_W'(code_word_ff);
   assign limit      = (max_attempts_ff == '0) ? kcl_pkg::MAX_ATT_W'(1) : max_attempts_ff;
   assign fail_inc   = fail_ff + 1'b1;

   // character 0 sits in the top used byte of the code word
   always_comb begin
      code_hit = 1'b1;
      for (int k = 0; k < CODE_LENGTH; k++) begin
         if (entry_ff[k] != code_ext[8*(CODE_LENGTH-1-k) +: 8]) begin
            code_hit = 1'b0;
         end
      end
   end

   always_comb begin
      entry_in     = entry_ff;
      stored_in    = stored_ff;
      echo_cnt_in  = echo_cnt_ff;
      fail_in      = fail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      echo_in      = echo_ff;
      ended_in     = ended_ff;
      matched_in   = matched_ff;
      verdict_in   = verdict_ff;
      report_in    = report_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         echo_in      = kcl_pkg::ECHO_NONE;
         ended_in     = 1'b0;
         matched_in   = 1'b0;
         verdict_in   = kcl_pkg::VERDICT_PENDING;
         report_in    = fail_ff;
         unique case (item.kind)
            kcl_pkg::KIND_ENTER: begin
               ended_in = 1'b1;
               if (code_hit) begin
                  matched_in = 1'b1;
                  verdict_in = kcl_pkg::VERDICT_GRANTED;
                  fail_in    = '0;
               end else begin
                  report_in = fail_inc;
                  if (fail_inc >= limit) begin
                     verdict_in = kcl_pkg::VERDICT_DENIED;
                     fail_in    = '0;
                  end else begin
                     fail_in = fail_inc;
                  end
               end
               for (int k = 0; k < CODE_LENGTH; k++) begin
                  entry_in[k] = '0;
               end
               stored_in   = '0;
               echo_cnt_in = '0;
            end
            kcl_pkg::KIND_DELETE: begin
               if (echo_cnt_ff != '0) begin
                  echo_in     = kcl_pkg::ECHO_ERASE;
                  echo_cnt_in = echo_cnt_ff - 1'b1;
                  if (stored_ff != '0) begin
                     stored_in = stored_ff - 1'b1;
                  end
               end
            end
            default: begin
               if (echo_cnt_ff < EC_MAX) begin
                  // store only while nothing echoed went unstored
                  if (stored_ff < SC_FULL && EC_W'(stored_ff) == echo_cnt_ff) begin
                     for (int k = 0; k < CODE_LENGTH; k++) begin
                        if (stored_ff == SC_W'(k)) begin
                           entry_in[k] = item.key;
                        end
                     end
                     stored_in = stored_ff + 1'b1;
                  end
                  echo_in     = kcl_pkg::ECHO_STAR;
                  echo_cnt_in = echo_cnt_ff + 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_word_ff    <= kcl_pkg::CODE_WORD_RESET;
         max_attempts_ff <= kcl_pkg::MAX_ATTEMPTS_RESET;
      end else if (csr_write_en) begin
         unique case (kcl_pkg::csr_index_type'(csr_index))
            kcl_pkg::CSR_CODE_WORD:    code_word_ff    <= csr_wdata;
            kcl_pkg::CSR_MAX_ATTEMPTS: max_attempts_ff <= csr_wdata[kcl_pkg::MAX_ATT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CODE_LENGTH; k++) begin
            entry_ff[k] <= '0;
         end
         stored_ff    <= '0;
         echo_cnt_ff  <= '0;
         fail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         entry_ff     <= entry_in;
         stored_ff    <= stored_in;
         echo_cnt_ff  <= echo_cnt_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      echo_ff    <= echo_in;
      ended_ff   <= ended_in;
      matched_ff <= matched_in;
      verdict_ff <= verdict_in;
      report_ff  <= report_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_echo_action     = echo_ff;
   assign rsp_attempt_ended   = ended_ff;
   assign rsp_attempt_matched = matched_ff;
   assign rsp_verdict         = verdict_ff;
   assign rsp_failures_so_far = report_ff;

endmodule

/* src/keypad_code_lock.sv */
// Path: a request is written into the queue, then taken by the lock engine into its output register.
// Throughput: one request per cycle while rsp_ready takes each response, set
//   by the lock engine and its output register; the two-entry queue keeps
//   intake going while a response waits to be taken.
// Reset: synchronous, active high; clears the entry buffer, counters and queue
//   and restores the code word and attempt limit. No clearing pass.
// ----------------------------------------------------------------------------
// keypad_code_lock
// Code lock fed one key per request: echo, delete, and code check on enter.
// ----------------------------------------------------------------------------
module keypad_code_lock #(
   parameter int CODE_LENGTH = 5,
   parameter int ECHO_MAX    = 63
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic                            csr_index,
   input  logic [kcl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [kcl_pkg::KEY_W-1:0]       req_key_code,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_echo_action,
   output logic                            rsp_attempt_ended,
   output logic                            rsp_attempt_matched,
   output logic [1:0]                      rsp_verdict,
   output logic [kcl_pkg::FAIL_W-1:0]      rsp_failures_so_far
);

   kcl_pkg::key_item_type front_item;
   kcl_pkg::key_item_type q_item;
   logic                  q_valid;
   logic                  q_ready;

   kcl_front u_front (
      .key_code (req_key_code),
      .item     (front_item)
   );

   kcl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (front_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   kcl_back #(
      .CODE_LENGTH (CODE_LENGTH),
      .ECHO_MAX    (ECHO_MAX)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .item_valid          (q_valid),
      .item_ready          (q_ready),
      .item                (q_item),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_echo_action     (rsp_echo_action),
      .rsp_attempt_ended   (rsp_attempt_ended),
      .rsp_attempt_matched (rsp_attempt_matched),
      .rsp_verdict         (rsp_verdict),
      .rsp_failures_so_far (rsp_failures_so_far)
   );

endmodule

/* src/kcl_checker.sv */
// ----------------------------------------------------------------------------
// kcl_checker
// Port-level checks on the keypad code lock responses.
// ----------------------------------------------------------------------------
`include "keypad_code_lock_defines.svh"

module kcl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [1:0]                      rsp_echo_action,
   input logic                            rsp_attempt_ended,
   input logic                            rsp_attempt_matched,
   input logic [1:0]                      rsp_verdict,
   input logic [kcl_pkg::FAIL_W-1:0]      rsp_failures_so_far
);

   logic [kcl_pkg::FAIL_W+5:0] rsp_fields;
   logic                       rsp_stalled;
   logic                       rsp_mid_attempt;
   logic                       rsp_no_outcome;
   logic                       rsp_match_seen;
   logic                       rsp_granted_end;
   logic                       rsp_enter_seen;
   logic                       rsp_no_echo;
   logic                       rsp_deny_seen;
   logic                       rsp_deny_ok;

   assign rsp_fields      = {rsp_echo_action, rsp_attempt_ended, rsp_attempt_matched,
                             rsp_verdict, rsp_failures_so_far};
   assign rsp_stalled     = rsp_valid && !rsp_ready;
   assign rsp_mid_attempt = rsp_valid && !rsp_attempt_ended;
   assign rsp_no_outcome  = (rsp_verdict == kcl_pkg::VERDICT_PENDING) && !rsp_attempt_matched;
   assign rsp_match_seen  = rsp_valid && rsp_attempt_matched;
   assign rsp_granted_end = rsp_attempt_ended && (rsp_verdict == kcl_pkg::VERDICT_GRANTED);
   assign rsp_enter_seen  = rsp_valid && rsp_attempt_ended;
   assign rsp_no_echo     = (rsp_echo_action == kcl_pkg::ECHO_NONE);
   assign rsp_deny_seen   = rsp_valid && (rsp_verdict == kcl_pkg::VERDICT_DENIED);
   assign rsp_deny_ok     = !rsp_attempt_matched && (rsp_failures_so_far != '0);

   `KCL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_fields))
   `KCL_ASSERT_NOW(a_no_verdict_midattempt, clock, reset, rsp_mid_attempt, rsp_no_outcome)
   `KCL_ASSERT_NOW(a_match_grants, clock, reset, rsp_match_seen, rsp_granted_end)
   `KCL_ASSERT_NOW(a_enter_no_echo, clock, reset, rsp_enter_seen, rsp_no_echo)
   `KCL_ASSERT_NOW(a_deny_counts, clock, reset, rsp_deny_seen, rsp_deny_ok)

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (.*);
